### rtl/core/tfpi_pkg.sv
// shared types and constants for the tilt filter pwm indicator
`default_nettype none

package tfpi_pkg;

   localparam int DATA_W      = 8;
   localparam int LINE_CNT    = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_X    = 2'd0;
   localparam logic [1:0] MODE_Y    = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam int LINE_POS_X = 0;
   localparam int LINE_POS_Y = 1;
   localparam int LINE_NEG_X = 2;
   localparam int LINE_NEG_Y = 3;

   localparam int LATCH_A = 0;
   localparam int LATCH_B = 1;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_SAMPLE,
      OP_TICK
   } op_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [DATA_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [LINE_CNT-1:0] pwm_lines;
      logic [LINE_CNT-1:0] indicator_leds;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic              axis;
      logic [DATA_W-1:0] sample;
   } work_type;

endpackage

`default_nettype wire

### rtl/core/tfpi_front.sv
// front end: accepts items, decodes the mode and queues the work
`default_nettype none

module tfpi_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire tfpi_pkg::req_type  req_data,
   output logic                    q_valid,
   output tfpi_pkg::work_type      q_head,
   input  wire logic               q_pop
);
   import tfpi_pkg::*;

   work_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   work_type          work;
   logic              push;

   always_comb begin
      work.sample = req_data.sample;
      work.axis   = 1'b0;
      work.op     = OP_NOP;
      unique case (req_data.mode)
         MODE_X: begin
            work.op = OP_SAMPLE;
         end
         MODE_Y: begin
            work.op   = OP_SAMPLE;
            work.axis = 1'b1;
         end
         MODE_TICK: begin
            work.op = OP_TICK;
         end
         default: begin
            work.op = OP_NOP;
         end
      endcase
   end

   assign req_stall = reset || (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= work;
      end
   end

endmodule

`default_nettype wire

### rtl/core/tfpi_back.sv
// back end: offset capture, window filter, duty split and pwm generation
`default_nettype none

module tfpi_back #(
   parameter int WINDOW_LEN = 16,
   parameter int SUM_SHIFT  = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire tfpi_pkg::work_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output tfpi_pkg::rsp_type       rsp_data
);
   import tfpi_pkg::*;

   localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W = $clog2(WINDOW_LEN) + DATA_W;

   // offset and window position, first stage
   logic [DATA_W-1:0] offset_ff   [2];
   logic              captured_ff [2];
   logic [POS_W-1:0]  pos_ff      [2];

   logic              a_valid_ff;
   op_type            a_op_ff, a_op_in;
   logic              a_axis_ff;
   logic [POS_W-1:0]  a_pos_ff;
   logic [DATA_W-1:0] a_corr_ff;

   logic [DATA_W-1:0] win_mem     [2][WINDOW_LEN];
   logic              win_live_ff [2][WINDOW_LEN];
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_live_ff;

   // filter and pwm state, second stage
   logic signed [SUM_W-1:0] sum_ff    [2];
   logic [DATA_W-1:0]       duty_ff   [LINE_CNT];
   logic [DATA_W-1:0]       shadow_ff [LINE_CNT];
   logic [DATA_W-1:0]       count_ff;
   logic                    latch_ff  [2];

   logic    out_valid_ff;
   rsp_type out_data_ff, out_data_in;

   logic adv;
   logic head_axis;
   logic capture;
   logic step_pos;
   logic b_write;
   logic b_tick;

   logic signed [DATA_W-1:0] old_val;
   logic signed [DATA_W-1:0] corr_val;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  shifted;
   logic signed [SUM_W:0]    wide;
   logic [SUM_W:0]           mag;
   logic [DATA_W-1:0]        mag_sat;

   logic [DATA_W-1:0]   count_in;
   logic [DATA_W-1:0]   shadow_in [LINE_CNT];
   logic [LINE_CNT-1:0] lines;
   logic                latch_in  [2];

   assign adv       = !out_valid_ff || !rsp_stall;
   assign q_pop     = adv && q_valid;
   assign head_axis = q_head.axis;
   assign capture   = q_pop && (q_head.op == OP_SAMPLE) && !captured_ff[head_axis];
   assign step_pos  = q_pop && (q_head.op == OP_SAMPLE) && captured_ff[head_axis];
   assign a_op_in   = capture ? OP_NOP : q_head.op;
   assign b_write   = adv && a_valid_ff && (a_op_ff == OP_SAMPLE);
   assign b_tick    = a_valid_ff && (a_op_ff == OP_TICK);

   always_ff @(posedge clock) begin
      if (reset) begin
         captured_ff[0] <= 1'b0;
         captured_ff[1] <= 1'b0;
         offset_ff[0]   <= '0;
         offset_ff[1]   <= '0;
         pos_ff[0]      <= '0;
         pos_ff[1]      <= '0;
         a_valid_ff     <= 1'b0;
      end else begin
         if (capture) begin
            captured_ff[head_axis] <= 1'b1;
            offset_ff[head_axis]   <= q_head.sample;
         end
         if (step_pos) begin
            pos_ff[head_axis] <= (pos_ff[head_axis] == POS_W'(WINDOW_LEN - 1)) ?
                                 '0 : pos_ff[head_axis] + 1'b1;
         end
         if (adv) begin
            a_valid_ff <= q_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_op_ff   <= a_op_in;
         a_axis_ff <= head_axis;
         a_pos_ff  <= pos_ff[head_axis];
         a_corr_ff <= q_head.sample - offset_ff[head_axis];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff <= win_mem[head_axis][pos_ff[head_axis]];
         rd_live_ff <= win_live_ff[head_axis][pos_ff[head_axis]];
      end
      if (b_write) begin
         win_mem[a_axis_ff][a_pos_ff] <= a_corr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < WINDOW_LEN; j++) begin
               win_live_ff[i][j] <= 1'b0;
            end
         end
      end else if (b_write) begin
         win_live_ff[a_axis_ff][a_pos_ff] <= 1'b1;
      end
   end

   // running sum and duty split
   always_comb begin
      old_val  = rd_live_ff ? rd_data_ff : '0;
      corr_val = a_corr_ff;
      sum_in   = sum_ff[a_axis_ff]
               + {{(SUM_W - DATA_W){corr_val[DATA_W-1]}}, corr_val}
               - {{(SUM_W - DATA_W){old_val[DATA_W-1]}}, old_val};
      shifted  = sum_in >>> SUM_SHIFT;
      wide     = {shifted[SUM_W-1], shifted};
      mag      = shifted[SUM_W-1] ? -wide : wide;
      mag_sat  = (mag > (SUM_W + 1)'(8'hFF)) ? 8'hFF : mag[DATA_W-1:0];
   end

   // counter, shadow reload, lines and direction latches
   always_comb begin
      count_in = b_tick ? count_ff + 1'b1 : count_ff;
      for (int k = 0; k < LINE_CNT; k++) begin
         shadow_in[k] = (b_tick && (count_in == '0)) ? duty_ff[k] : shadow_ff[k];
         lines[k]     = (count_in < shadow_in[k]);
      end
      latch_in[LATCH_A] = latch_ff[LATCH_A];
      latch_in[LATCH_B] = latch_ff[LATCH_B];
      if (b_tick) begin
         if (lines[LINE_POS_Y]) latch_in[LATCH_A] = 1'b1;
         if (lines[LINE_NEG_Y]) latch_in[LATCH_A] = 1'b0;
         if (lines[LINE_NEG_X]) latch_in[LATCH_B] = 1'b1;
         if (lines[LINE_POS_X]) latch_in[LATCH_B] = 1'b0;
      end
      out_data_in.pwm_lines      = lines;
      out_data_in.indicator_leds = {!latch_in[LATCH_B], latch_in[LATCH_B],
                                    !latch_in[LATCH_A], latch_in[LATCH_A]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         count_ff     <= '0;
         latch_ff[0]  <= 1'b0;
         latch_ff[1]  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < LINE_CNT; k++) begin
            duty_ff[k]   <= '0;
            shadow_ff[k] <= '0;
         end
      end else if (adv) begin
         out_valid_ff <= a_valid_ff;
         if (b_write) begin
            sum_ff[a_axis_ff] <= sum_in;
            if (shifted[SUM_W-1]) begin
               duty_ff[{1'b0, a_axis_ff}] <= '0;
               duty_ff[{1'b1, a_axis_ff}] <= mag_sat;
            end else begin
               duty_ff[{1'b0, a_axis_ff}] <= mag_sat;
               duty_ff[{1'b1, a_axis_ff}] <= '0;
            end
         end
         if (a_valid_ff) begin
            count_ff    <= count_in;
            latch_ff[0] <= latch_in[0];
            latch_ff[1] <= latch_in[1];
            for (int k = 0; k < LINE_CNT; k++) begin
               shadow_ff[k] <= shadow_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && a_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

### rtl/core/tilt_filter_to_pwm_indicator.sv
// top level of the tilt filter pwm indicator
//
// req channel: one item per handshake, mode selects an x sample, a y sample,
// a pwm tick or, for the spare code, nothing; sample is the raw signed axis reading
// rsp channel: exactly one item per accepted req item, in order, carrying
// the four pwm lines and four indicator leds after that item took effect
// an accepted item passes through the queue, the first-stage registers and
// the rsp register before it shows on rsp
// throughput is one item per cycle while the receiver does not stall; the
// window memory read is registered, which sets the two-stage back end
// a two-entry queue sits between decode and the back end; req_stall rises
// only when that queue is full or reset is high, so the sender keeps going
// while a finished item waits in the rsp register
// when rsp_stall is high with an rsp item valid, that item holds and the back end stops
// reset clears offsets, window (through per-entry valid bits), sums, duties,
// shadows, counter and latches; req_stall is high during reset
// the first sample of each axis after reset only sets that axis offset
`default_nettype none

module tilt_filter_to_pwm_indicator #(
   parameter int WINDOW_LEN = 16,
   parameter int SUM_SHIFT  = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tfpi_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tfpi_pkg::rsp_type      rsp_data
);
   import tfpi_pkg::*;

   logic     q_valid;
   logic     q_pop;
   work_type q_head;

   tfpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   tfpi_back #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_SHIFT  (SUM_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/core/tfpi_checker.sv
// port checker for the tilt filter pwm indicator and its bind
`default_nettype none

module tfpi_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire tfpi_pkg::rsp_type rsp_data
);

   assert property (@(posedge clock) reset |-> req_stall)
      else $error("req not stalled during reset");

   assert property (@(posedge clock) reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("rsp item too early after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.indicator_leds[0] != rsp_data.indicator_leds[1]) &&
                    (rsp_data.indicator_leds[2] != rsp_data.indicator_leds[3]))
      else $error("indicator pair not complementary");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp item changed while stalled");

endmodule

bind tilt_filter_to_pwm_indicator tfpi_checker u_checker (.*);

`default_nettype wire

### verif/tilt_filter_to_pwm_indicator_checker.sv
// checker for the tilt filter pwm indicator: predicts pwm lines and leds and compares them
module tilt_filter_to_pwm_indicator_checker #(
   parameter int WINDOW_LEN = 16,
   parameter int SUM_SHIFT  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  tfpi_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  tfpi_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                rsp_owed
);
   import tfpi_pkg::*;

   logic [7:0]        zero_ref [2];
   bit                zero_set [2];
   logic signed [7:0] tilt_hist [2][WINDOW_LEN];
   int                hist_pos [2];
   int                tilt_sum [2];
   logic [7:0]        duty_next [LINE_CNT];
   logic [7:0]        duty_live [LINE_CNT];
   logic [7:0]        pwm_count;
   bit                dir_latch [2];
   rsp_type           indicator_due [$];

   task automatic clear_tilt_state();
      for (int a = 0; a < 2; a++) begin
         zero_ref[a]  = '0;
         zero_set[a]  = 1'b0;
         hist_pos[a]  = 0;
         tilt_sum[a]  = 0;
         dir_latch[a] = 1'b0;
         for (int k = 0; k < WINDOW_LEN; k++) tilt_hist[a][k] = '0;
      end
      for (int k = 0; k < LINE_CNT; k++) begin
         duty_next[k] = '0;
         duty_live[k] = '0;
      end
      pwm_count = '0;
   endtask

   function automatic logic [LINE_CNT-1:0] line_state();
      logic [LINE_CNT-1:0] lines;
      lines = '0;
      for (int k = 0; k < LINE_CNT; k++)
         if (pwm_count < duty_live[k]) lines[k] = 1'b1;
      return lines;
   endfunction

   task automatic apply_reading(input int axis, input logic [7:0] raw);
      logic signed [7:0] corr;
      int                p;
      int                scaled;
      if (!zero_set[axis]) begin
         zero_ref[axis] = raw;
         zero_set[axis] = 1'b1;
         return;
      end
      corr = raw - zero_ref[axis];
      p = hist_pos[axis];
      tilt_sum[axis] += int'(corr) - int'(tilt_hist[axis][p]);
      tilt_hist[axis][p] = corr;
      hist_pos[axis] = (p + 1) % WINDOW_LEN;
      scaled = tilt_sum[axis] >>> SUM_SHIFT;
      if (scaled >= 0) begin
         duty_next[LINE_POS_X + axis] = (scaled > 255) ? 8'd255 : 8'(scaled);
         duty_next[LINE_NEG_X + axis] = '0;
      end else begin
         duty_next[LINE_POS_X + axis] = '0;
         duty_next[LINE_NEG_X + axis] = (-scaled > 255) ? 8'd255 : 8'(-scaled);
      end
   endtask

   task automatic advance_pwm();
      logic [LINE_CNT-1:0] lines;
      pwm_count = pwm_count + 8'd1;
      if (pwm_count == 8'd0) duty_live = duty_next;
      lines = line_state();
      if (lines[LINE_POS_Y]) dir_latch[LATCH_A] = 1'b1;
      if (lines[LINE_NEG_Y]) dir_latch[LATCH_A] = 1'b0;
      if (lines[LINE_NEG_X]) dir_latch[LATCH_B] = 1'b1;
      if (lines[LINE_POS_X]) dir_latch[LATCH_B] = 1'b0;
   endtask

   task automatic predict_indicators(input req_type item, output rsp_type outcome);
      case (item.mode)
         MODE_X:    apply_reading(0, item.sample);
         MODE_Y:    apply_reading(1, item.sample);
         MODE_TICK: advance_pwm();
         default:   ;
      endcase
      outcome.pwm_lines      = line_state();
      outcome.indicator_leds = {!dir_latch[LATCH_B], dir_latch[LATCH_B],
                                !dir_latch[LATCH_A], dir_latch[LATCH_A]};
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         clear_tilt_state();
         indicator_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (indicator_due.size() == 0) begin
               $display("%0t: rsp item with none expected, actual lines %h leds %h",
                        $time, got.pwm_lines, got.indicator_leds);
               mismatch_count++;
            end else begin
               want = indicator_due.pop_front();
               if (got.pwm_lines !== want.pwm_lines ||
                   got.indicator_leds !== want.indicator_leds) begin
                  $display("%0t: expected lines %h leds %h, actual lines %h leds %h",
                           $time, want.pwm_lines, want.indicator_leds,
                           got.pwm_lines, got.indicator_leds);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_indicators(req_data, want);
            indicator_due.push_back(want);
         end
      end
      rsp_owed = indicator_due.size();
   end
endmodule

### verif/tilt_filter_to_pwm_indicator_tb.sv
// testbench top for the tilt filter pwm indicator: stimulus, receiver stalls and verdict
module tilt_filter_to_pwm_indicator_tb;
   import tfpi_pkg::*;

   localparam int WINDOW_LEN   = 16;
   localparam int SUM_SHIFT    = 2;
   localparam int RANDOM_ITEMS = 2000;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [1:0]        MODE_SPARE = 2'd3;
   localparam logic signed [7:0] X_ZERO     = -8'sd128;
   localparam logic signed [7:0] Y_ZERO     = 8'sd127;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatches;
   int      owed;
   int      burst_left  = 0;
   int      stall_cycle = 0;
   int      idle_cycles = 0;
   logic signed [7:0] lean [2];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tilt_filter_to_pwm_indicator #(
      .WINDOW_LEN(WINDOW_LEN),
      .SUM_SHIFT (SUM_SHIFT)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   tilt_filter_to_pwm_indicator_checker #(
      .WINDOW_LEN(WINDOW_LEN),
      .SUM_SHIFT (SUM_SHIFT)
   ) check_u (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatches),
      .rsp_owed      (owed)
   );

   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case ((stall_cycle / 300) % 4)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_cycle % 7) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tilt_filter_to_pwm_indicator verification failed");
            $finish;
         end
      end
   end

   function automatic req_type make_req(input logic [1:0] mode, input logic signed [7:0] sample);
      req_type item;
      item.mode   = mode;
      item.sample = sample;
      return item;
   endfunction

   // mostly readings near a lean that changes every 150 items, some raw noise
   function automatic logic [7:0] tilted_raw(input int axis);
      logic [7:0] zero;
      zero = axis ? Y_ZERO : X_ZERO;
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return 8'(zero + lean[axis] + $urandom_range(0, 15) - 8);
   endfunction

   task automatic send_req(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      req_type item;
      int      pick;
      lean[0] = '0;
      lean[1] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_req(make_req(MODE_TICK, 8'sh00));
      send_req(make_req(MODE_X, X_ZERO));
      send_req(make_req(MODE_SPARE, 8'sh55));
      send_req(make_req(MODE_Y, Y_ZERO));
      send_req(make_req(MODE_X, 8'sd127));
      send_req(make_req(MODE_X, -8'sd128));
      send_req(make_req(MODE_Y, -8'sd128));
      send_req(make_req(MODE_Y, 8'sd127));
      send_req(make_req(MODE_X, 8'sd0));
      send_req(make_req(MODE_Y, 8'sd0));
      send_req(make_req(MODE_X, -8'sd1));
      send_req(make_req(MODE_Y, -8'sd1));
      send_req(make_req(MODE_SPARE, -8'sh56));
      send_req(make_req(MODE_TICK, -8'sd1));
      send_req(make_req(MODE_TICK, -8'sd128));
      send_req(make_req(MODE_TICK, 8'sd127));
      send_req(make_req(MODE_TICK, 8'sh2A));
      send_req(make_req(MODE_TICK, 8'sh15));

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 150 == 0) begin
            lean[0] = 8'($urandom);
            lean[1] = 8'($urandom);
         end
         pick = $urandom_range(0, 99);
         if (pick < 68)      item = make_req(MODE_TICK, 8'($urandom));
         else if (pick < 82) item = make_req(MODE_X, tilted_raw(0));
         else if (pick < 96) item = make_req(MODE_Y, tilted_raw(1));
         else                item = make_req(MODE_SPARE, 8'($urandom));
         send_req(item);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tilt_filter_to_pwm_indicator verification clean");
      else
         $display("tilt_filter_to_pwm_indicator verification failed");
      $finish;
   end
endmodule

### filelist.f
rtl/core/tfpi_pkg.sv
rtl/core/tfpi_front.sv
rtl/core/tfpi_back.sv
rtl/core/tilt_filter_to_pwm_indicator.sv
rtl/core/tfpi_checker.sv
verif/tilt_filter_to_pwm_indicator_checker.sv
verif/tilt_filter_to_pwm_indicator_tb.sv
